### hw/rtl/vigenere_stream_cipher_unit_defines.svh
// Assertion macros shared by the Vigenere cipher RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef VIGENERE_STREAM_CIPHER_UNIT_DEFINES_SVH
`define VIGENERE_STREAM_CIPHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define VSC_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("vsc assertion failed");
`define VSC_ASSERT_ALWAYS(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) \
    else $error("vsc assertion failed");
`else
`define VSC_ASSERT(label, clk_s, rst_s, prop)
`define VSC_ASSERT_ALWAYS(label, clk_s, prop)
`endif

`endif

### hw/rtl/vsc_pkg.sv
// Package for the Vigenere cipher unit: codes, character constants and types.
// No dependencies; used by every module of the block.
package vsc_pkg;

  localparam int SLOT_W = 4;
  localparam int LEN_W  = 5;
  localparam int LEN_MAX = 31;
  localparam int SLOT_COUNT = 16;

  localparam logic [7:0] UPPER_A     = 8'd65;
  localparam logic [7:0] UPPER_Z     = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] LETTER_A    = 8'd97;
  localparam logic [7:0] LETTER_Z    = 8'd122;
  localparam logic [6:0] KEY_MIN     = 7'd97;
  localparam logic [6:0] KEY_MAX     = 7'd122;
  localparam logic [6:0] SHIFT_BIAS  = 7'd96;
  localparam logic [5:0] ALPHA_SIZE  = 6'd26;

  typedef enum logic {
    OP_TEXT      = 1'b0,
    OP_KEY_WRITE = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    CFG_MODE       = 1'b0,
    CFG_KEY_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [4:0]        shift;
  } key_wr_t;

  // Key letters below 'a' saturate to a shift of 1, above 'z' to 26.
  function automatic logic [4:0] letter_to_shift(input logic [6:0] letter);
    logic [6:0] diff;
    diff = letter - SHIFT_BIAS;
    if (letter < KEY_MIN) begin
      return 5'd1;
    end else if (letter > KEY_MAX) begin
      return 5'd26;
    end else begin
      return diff[4:0];
    end
  endfunction

endpackage

### hw/rtl/vigenere_stream_cipher_unit.sv
// Top level of the Vigenere stream cipher unit.
// Depends on vsc_pkg, vsc_key_store, vsc_shift_lane and the assertion header.
//
// Usage: requests arrive on req_valid/req_ready with opcode, text_byte,
// key_letter, key_slot and start_of_message. A key write request (opcode 1)
// stores a shift in the key store and produces no result. A text request
// (opcode 0) produces one result on rsp_valid/rsp_ready carrying out_byte
// and was_letter. Mode and key length are set through cfg_we, cfg_index
// and cfg_data while no request is in flight.
// A text request waits in the input register and moves into the result
// register, showing up on rsp_valid, once that register is free or being
// emptied; a receiver stall can hold it there. Throughput is one
// request per cycle while the receiver keeps up, set by the key position
// update between the two registers.
// When the receiver stalls, the waiting result holds in the result register
// while one more request can still enter the input register; req_ready drops
// only when both are full. Key writes never wait on the receiver.
// Reset clears both valid flags, the key position, mode (encode) and key
// length (one). Key store contents are undefined until written.
`include "vigenere_stream_cipher_unit_defines.svh"

module vigenere_stream_cipher_unit #(
  parameter int KEY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        opcode,
  input  logic [7:0]  text_byte,
  input  logic [6:0]  key_letter,
  input  logic [3:0]  key_slot,
  input  logic        start_of_message,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [7:0]  out_byte,
  output logic        was_letter
);

  localparam int LW = vsc_pkg::LEN_W;
  localparam int MAX_LEN = (KEY_DEPTH < vsc_pkg::LEN_MAX) ? KEY_DEPTH : vsc_pkg::LEN_MAX;
  localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int STORE_DEPTH =
      (KEY_DEPTH < vsc_pkg::SLOT_COUNT) ? KEY_DEPTH : vsc_pkg::SLOT_COUNT;

  vsc_pkg::mode_t   mode;
  logic [LW-1:0]    key_length;
  logic [LW-1:0]    eff_len;

  logic             s1_valid;
  vsc_pkg::opcode_t s1_opcode;
  logic [7:0]       s1_text;
  logic [6:0]       s1_letter;
  logic [3:0]       s1_slot;
  logic             s1_start;
  logic             s1_adv;
  logic             s1_is_text;

  logic [POS_W-1:0] key_pos;
  logic [LW-1:0]    pos_base;
  logic [LW-1:0]    pos_use;
  logic [LW-1:0]    pos_inc;
  logic [LW-1:0]    pos_wrap;

  vsc_pkg::key_wr_t key_wr;
  logic [4:0]       cur_shift;
  logic             lane_letter;
  logic [7:0]       lane_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= vsc_pkg::MODE_ENCODE;
      key_length <= LW'(1);
    end else if (cfg_we) begin
      unique case (vsc_pkg::cfg_index_t'(cfg_index))
        vsc_pkg::CFG_MODE: begin
          mode <= vsc_pkg::mode_t'(cfg_data[0]);
        end
        vsc_pkg::CFG_KEY_LENGTH: begin
          key_length <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (32'(key_length) > MAX_LEN) begin
      eff_len = LW'(MAX_LEN);
    end else begin
      eff_len = key_length;
    end
  end

  assign s1_is_text = (s1_opcode == vsc_pkg::OP_TEXT);
  assign s1_adv     = s1_valid && (!s1_is_text || !rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_opcode <= vsc_pkg::opcode_t'(opcode);
      s1_text   <= text_byte;
      s1_letter <= key_letter;
      s1_slot   <= key_slot;
      s1_start  <= start_of_message;
    end
  end

  always_comb begin
    pos_base = s1_start ? '0 : LW'(key_pos);
    pos_use  = (pos_base >= eff_len) ? '0 : pos_base;
    pos_inc  = pos_use + LW'(1);
    pos_wrap = (pos_inc >= eff_len) ? '0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos <= '0;
    end else if (s1_adv && s1_is_text) begin
      if (lane_letter) begin
        key_pos <= POS_W'(pos_wrap);
      end else begin
        key_pos <= POS_W'(pos_base);
      end
    end
  end

  always_comb begin
    key_wr.en    = s1_adv && !s1_is_text;
    key_wr.slot  = s1_slot;
    key_wr.shift = vsc_pkg::letter_to_shift(s1_letter);
  end

  vsc_key_store #(
    .DEPTH (STORE_DEPTH)
  ) u_key_store (
    .clk      (clk),
    .wr       (key_wr),
    .rd_idx   (pos_use),
    .rd_shift (cur_shift)
  );

  vsc_shift_lane u_shift_lane (
    .text_byte (s1_text),
    .shift     (cur_shift),
    .mode      (mode),
    .is_letter (lane_letter),
    .out_byte  (lane_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv && s1_is_text) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_text) begin
      out_byte   <= lane_byte;
      was_letter <= lane_letter;
    end
  end

  `VSC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!rsp_valid && !s1_valid))
  `VSC_ASSERT(a_text_gives_result, clk, rst, (s1_adv && s1_is_text) |=> rsp_valid)
  `VSC_ASSERT(a_stage_holds, clk, rst, (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_text) && $stable(s1_opcode)))
  `VSC_ASSERT(a_pos_in_range, clk, rst, 32'(key_pos) < MAX_LEN)

endmodule

### hw/rtl/vsc_key_store.sv
// Key shift store: one write port and one combinational read port.
// Depends on vsc_pkg for the write request struct and widths.
module vsc_key_store #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  vsc_pkg::key_wr_t           wr,
  input  logic [vsc_pkg::LEN_W-1:0]  rd_idx,
  output logic [4:0]                 rd_shift
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [4:0] shifts [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.slot) < DEPTH)) begin
      shifts[wr.slot[IDX_W-1:0]] <= wr.shift;
    end
  end

  // Positions past the store were never written and read as zero.
  always_comb begin
    if (32'(rd_idx) < DEPTH) begin
      rd_shift = shifts[rd_idx[IDX_W-1:0]];
    end else begin
      rd_shift = '0;
    end
  end

endmodule

### hw/rtl/vsc_shift_lane.sv
// Byte lane: case folding, letter detection and modulo-26 shift of one byte.
// Depends on vsc_pkg for character constants and the mode type.
module vsc_shift_lane (
  input  logic [7:0]     text_byte,
  input  logic [4:0]     shift,
  input  vsc_pkg::mode_t mode,
  output logic           is_letter,
  output logic [7:0]     out_byte
);

  logic [7:0] folded;
  logic [7:0] rel;
  logic [5:0] off;
  logic [5:0] sh;
  logic [5:0] enc_sum;
  logic [5:0] enc;
  logic [5:0] dec;
  logic [5:0] res;

  always_comb begin
    if (text_byte >= vsc_pkg::UPPER_A && text_byte <= vsc_pkg::UPPER_Z) begin
      folded = text_byte + vsc_pkg::CASE_OFFSET;
    end else begin
      folded = text_byte;
    end
    is_letter = (folded >= vsc_pkg::LETTER_A) && (folded <= vsc_pkg::LETTER_Z);

    rel     = folded - vsc_pkg::LETTER_A;
    off     = {1'b0, rel[4:0]};
    sh      = {1'b0, shift};
    enc_sum = off + sh;
    if (enc_sum >= vsc_pkg::ALPHA_SIZE) begin
      enc = enc_sum - vsc_pkg::ALPHA_SIZE;
    end else begin
      enc = enc_sum;
    end
    if (off >= sh) begin
      dec = off - sh;
    end else begin
      dec = off + vsc_pkg::ALPHA_SIZE - sh;
    end
    res = (mode == vsc_pkg::MODE_DECODE) ? dec : enc;

    if (is_letter) begin
      out_byte = vsc_pkg::LETTER_A + {2'b00, res};
    end else begin
      out_byte = folded;
    end
  end

endmodule

### sim/vigenere_stream_cipher_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Vigenere stream cipher unit.
// Holds a scoreboard class with its own cipher predictor; needs vsc_pkg and the unit's RTL.

module vigenere_stream_cipher_unit_tb;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_letter;
  } cipher_out_t;

  class cipher_scoreboard;
    logic [4:0]      key_shifts [vsc_pkg::SLOT_COUNT];
    int              key_pos;
    vsc_pkg::mode_t  mode;
    logic [4:0]      key_len;
    cipher_out_t     expected_out [$];
    int              mismatches;

    function new();
      key_pos = 0;
      mode = vsc_pkg::MODE_ENCODE;
      key_len = 5'd1;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void set_reg(vsc_pkg::cfg_index_t idx, logic [4:0] val);
      if (idx == vsc_pkg::CFG_MODE) begin
        mode = vsc_pkg::mode_t'(val[0]);
      end else begin
        key_len = val;
      end
    endfunction

    function void note_request(vsc_pkg::opcode_t op, logic [7:0] tb, logic [6:0] kl,
                               logic [3:0] ks, logic som);
      int c;
      int v;
      int sh;
      int span;
      cipher_out_t r;
      if (op == vsc_pkg::OP_KEY_WRITE) begin
        if (kl < vsc_pkg::KEY_MIN) begin
          key_shifts[ks] = 5'd1;
        end else if (kl > vsc_pkg::KEY_MAX) begin
          key_shifts[ks] = 5'd26;
        end else begin
          key_shifts[ks] = 5'(int'(kl) - 96);
        end
        return;
      end
      if (som) begin
        key_pos = 0;
      end
      c = tb;
      if (c >= vsc_pkg::UPPER_A && c <= vsc_pkg::UPPER_Z) begin
        c = c + vsc_pkg::CASE_OFFSET;
      end
      if (c >= vsc_pkg::LETTER_A && c <= vsc_pkg::LETTER_Z) begin
        span = key_len;
        if (span < 1) span = 1;
        if (span > vsc_pkg::SLOT_COUNT) span = vsc_pkg::SLOT_COUNT;
        if (key_pos >= span) key_pos = 0;
        sh = key_shifts[key_pos];
        if (mode == vsc_pkg::MODE_ENCODE) begin
          v = c + sh;
          if (v > 122) v = v - 26;
        end else begin
          v = (c < 97 + sh) ? c + 26 - sh : c - sh;
        end
        key_pos = key_pos + 1;
        if (key_pos >= span) key_pos = 0;
        r.out_byte = 8'(v);
        r.was_letter = 1'b1;
      end else begin
        r.out_byte = 8'(c);
        r.was_letter = 1'b0;
      end
      expected_out.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] ob, logic wl);
      cipher_out_t e;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_byte=%h", ob));
        return;
      end
      e = expected_out.pop_front();
      if (ob !== e.out_byte) begin
        report_mismatch($sformatf("out_byte %h, expected %h", ob, e.out_byte));
      end
      if (wl !== e.was_letter) begin
        report_mismatch($sformatf("was_letter %b, expected %b", wl, e.was_letter));
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [4:0] cfg_data;
  logic       req_valid;
  logic       req_ready;
  logic       opcode;
  logic [7:0] text_byte;
  logic [6:0] key_letter;
  logic [3:0] key_slot;
  logic       start_of_message;
  logic       rsp_valid;
  logic       rsp_ready;
  logic [7:0] out_byte;
  logic       was_letter;

  cipher_scoreboard sb = new();
  bit sender_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_hold = 0;

  vigenere_stream_cipher_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .opcode(opcode),
    .text_byte(text_byte),
    .key_letter(key_letter),
    .key_slot(key_slot),
    .start_of_message(start_of_message),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .out_byte(out_byte),
    .was_letter(was_letter)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_request(vsc_pkg::opcode_t op, logic [7:0] tb, logic [6:0] kl,
                              logic [3:0] ks, logic som);
    int gap;
    if (sender_burst || $urandom_range(0, 3) == 0) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    text_byte <= tb;
    key_letter <= kl;
    key_slot <= ks;
    start_of_message <= som;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    sb.note_request(op, tb, kl, ks, som);
  endtask

  task automatic send_text(logic [7:0] tb, logic som);
    send_request(vsc_pkg::OP_TEXT, tb, 7'($urandom), 4'($urandom), som);
  endtask

  task automatic send_key(logic [3:0] ks, logic [6:0] kl);
    send_request(vsc_pkg::OP_KEY_WRITE, 8'($urandom), kl, ks, 1'($urandom));
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(vsc_pkg::cfg_index_t idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [7:0] tb;
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 3) == 0) begin
        send_key(4'($urandom), 7'($urandom));
      end else begin
        send_key(4'($urandom), 7'($urandom_range(97, 122)));
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        tb = 8'($urandom_range(97, 122));
      end else if (pick < 8) begin
        tb = 8'($urandom_range(65, 90));
      end else begin
        tb = 8'($urandom);
      end
      send_text(tb, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin : response_sink
    int stall;
    logic [7:0] got_byte;
    logic got_flag;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else if (rx_burst || $urandom_range(0, 3) == 0) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(negedge clk); while (!rsp_valid);
      got_byte = out_byte;
      got_flag = was_letter;
      @(posedge clk);
      sb.check_result(got_byte, got_flag);
      if ($urandom_range(0, 63) == 0) begin
        rx_burst = !rx_burst;
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [6:0] odd_letters [6];
    logic [7:0] probe_bytes [10];
    logic [4:0] len;
    int i;
    int phase;
    odd_letters = '{vsc_pkg::KEY_MIN, vsc_pkg::KEY_MAX, 7'd0, 7'd96, 7'd123, 7'd127};
    probe_bytes = '{8'd97, 8'd122, 8'd65, 8'd90, 8'd64, 8'd91, 8'd96, 8'd123,
                    8'd255, 8'd0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = vsc_pkg::CFG_MODE;
    cfg_data = '0;
    req_valid = 1'b0;
    opcode = vsc_pkg::OP_TEXT;
    text_byte = '0;
    key_letter = '0;
    key_slot = '0;
    start_of_message = 1'b0;
    rsp_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every key slot first, including letters outside a..z that saturate.
    for (i = 0; i < vsc_pkg::SLOT_COUNT; i++) begin
      send_key(4'(i), (i < 6) ? odd_letters[i] : 7'($urandom_range(97, 122)));
    end
    wait_idle();
    write_reg(vsc_pkg::CFG_KEY_LENGTH, 5'd31);
    for (i = 0; i < 10; i++) begin
      send_text(probe_bytes[i], i == 0);
    end

    // Lowering the key length below the current position wraps it to zero.
    wait_idle();
    write_reg(vsc_pkg::CFG_KEY_LENGTH, 5'd5);
    send_text(8'd98, 1'b1);
    send_text(8'd99, 1'b0);
    send_text(8'd100, 1'b0);
    wait_idle();
    write_reg(vsc_pkg::CFG_KEY_LENGTH, 5'd2);
    send_text(8'd101, 1'b0);

    wait_idle();
    write_reg(vsc_pkg::CFG_MODE, vsc_pkg::MODE_DECODE);
    write_reg(vsc_pkg::CFG_KEY_LENGTH, 5'd0);
    send_text(8'd97, 1'b1);
    send_text(8'd122, 1'b0);
    send_text(8'd81, 1'b0);

    for (phase = 0; phase < 14; phase++) begin
      wait_idle();
      case (phase)
        0: len = 5'd0;
        1: len = 5'd1;
        2: len = 5'd16;
        3: len = 5'd31;
        4: len = 5'd17;
        default: len = 5'($urandom_range(0, 31));
      endcase
      write_reg(vsc_pkg::CFG_MODE,
                (phase % 2 == 0) ? vsc_pkg::MODE_ENCODE : vsc_pkg::MODE_DECODE);
      write_reg(vsc_pkg::CFG_KEY_LENGTH, len);
      sender_burst = (phase % 4 == 3) || (phase == 5);
      if (phase == 5) begin
        rx_hold = 400;
      end
      repeat (95) random_request();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### vigenere_stream_cipher_unit.f
+incdir+hw/rtl
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_key_store.sv
hw/rtl/vsc_shift_lane.sv
hw/rtl/vigenere_stream_cipher_unit.sv
sim/vigenere_stream_cipher_unit_tb.sv
